@@ rtl/core/third_derivative_flexion_stencil_assert.svh @@
// Assertion macros shared by the stencil checker.
`ifndef THIRD_DERIVATIVE_FLEXION_STENCIL_ASSERT_SVH
`define THIRD_DERIVATIVE_FLEXION_STENCIL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TDFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdfs check failed");

// Next-cycle implication, disabled during reset.
`define TDFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdfs check failed");

`endif

@@ rtl/core/tdfs_pkg.sv @@
// Package with constants and types of the flexion stencil.
package tdfs_pkg;
   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;
   localparam int DIM_W        = 14;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int SAMPLE_W     = 32;
   localparam int POS_W        = 10;
   localparam int FLEX_W       = 48;
   localparam int RSP_DATA_W   = 120;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLEX_KIND  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SCALE = 2'd3;

   localparam logic KIND_FIRST = 1'b0;

   typedef struct packed {
      logic                     last;
      logic signed [FLEX_W-1:0] flex_im;
      logic signed [FLEX_W-1:0] flex_re;
      logic [POS_W-1:0]         ccol;
      logic [POS_W-1:0]         crow;
   } rsp_item_type;
endpackage

@@ rtl/core/third_derivative_flexion_stencil.sv @@
// Top level of the third-derivative flexion stencil.
// Potential samples (signed Q16.16) arrive in raster order, one request per
// cycle while req_tready is high. A line store RAM of MAX_COLS words x six
// rows plus a 7x7 window register array give, for each interior center (three
// or more samples from every edge), the finite-difference third derivatives;
// kind 0 forms first flexion, kind 1 second flexion, each part scaled by the
// 2/dx^3 register, rounded half away from zero and saturated to 48 bits.
// Throughput is one request per cycle while req_tready is high; each accepted
// request writes the line store (one read and one write port) and shifts the
// window. A result passes stages s1 to s4 into an 8-entry output queue;
// req_tready drops only when the queue plus the items in flight would fill it.
// The line store is not cleared after reset; a fresh frame rewrites each entry
// before a result uses it. Grid size is clamped to [7, MAX_ROWS/MAX_COLS].
// rsp_tdata: center_row[9:0], center_col[19:10], flexion_real[67:20],
// flexion_imag[115:68], zero padding[119:116]; rsp_tlast = frame_last.
module third_derivative_flexion_stencil #(
   parameter int MAX_COLS = tdfs_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tdfs_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tdfs_pkg::SAMPLE_W-1:0]     req_tdata,   // potential_sample[31:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tdfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // row, col, real, imag
   output logic                              rsp_tlast,   // frame_last
   input  logic                              csr_we,
   input  logic [tdfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tdfs_pkg::*;

   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int LINE_W = 6 * SAMPLE_W;
   localparam int SW     = 40;   // combined stencil sum
   localparam int PW     = 58;   // scaled product path
   localparam int QD     = 8;    // output queue depth
   localparam int QA     = $clog2(QD);

   // configuration
   logic [10:0] rows_ff, cols_ff;
   logic        kind_ff;
   logic [31:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 11'd1024;
         cols_ff  <= 11'd1024;
         kind_ff  <= KIND_FIRST;
         scale_ff <= 32'd65536;
      end else if (csr_we) begin
         case (csr_index)
            REG_GRID_ROWS:  rows_ff  <= csr_wdata[10:0];
            REG_GRID_COLS:  cols_ff  <= csr_wdata[10:0];
            REG_FLEX_KIND:  kind_ff  <= csr_wdata[0];
            REG_STEP_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] rows_eff, cols_eff, rows_x, cols_x;
   always_comb begin
      rows_x = DIM_W'(rows_ff);
      cols_x = DIM_W'(cols_ff);
      if (rows_x < DIM_W'(7))             rows_eff = DIM_W'(7);
      else if (rows_x > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
      else                                rows_eff = rows_x;
      if (cols_x < DIM_W'(7))             cols_eff = DIM_W'(7);
      else if (cols_x > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
      else                                cols_eff = cols_x;
   end

   // raster counters
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [DIM_W-1:0] r_x, c_x;
   logic accept, emit, last;

   assign accept = req_tvalid && req_tready;
   assign r_x    = DIM_W'(row_ff);
   assign c_x    = DIM_W'(col_ff);
   assign emit   = (r_x >= DIM_W'(6)) && (c_x >= DIM_W'(6)) &&
                   (r_x < rows_eff) && (c_x < cols_eff);
   assign last   = (r_x == rows_eff - DIM_W'(1)) && (c_x == cols_eff - DIM_W'(1));

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (c_x >= cols_eff - DIM_W'(1)) begin
            col_in = '0;
            if (r_x >= rows_eff - DIM_W'(1)) row_in = '0;
            else                             row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // stage 1: line store read returns
   logic                s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [POS_W-1:0]    s1_crow_ff, s1_ccol_ff;
   logic [LINE_W-1:0]   line_rdata, line_wdata;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
      s1_emit_ff   <= emit;
      s1_last_ff   <= last;
      s1_sample_ff <= req_tdata;
      s1_col_ff    <= col_ff;
      s1_crow_ff   <= POS_W'(r_x - DIM_W'(3));
      s1_ccol_ff   <= POS_W'(c_x - DIM_W'(3));
   end

   // rows shift down one slot, newest sample in the top slot
   assign line_wdata = {s1_sample_ff, line_rdata[LINE_W-1:SAMPLE_W]};

   tdfs_ram #(.WIDTH(LINE_W), .DEPTH(MAX_COLS)) u_line (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata (line_wdata),
      .raddr (col_ff),
      .rdata (line_rdata)
   );

   // 7x7 window: [line][column], line 6 newest, column 6 newest
   logic signed [SAMPLE_W-1:0] window_ff [7][7];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 7; k++)
            for (int x = 0; x < 7; x++) window_ff[k][x] <= '0;
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 7; k++) begin
            for (int x = 0; x < 6; x++) window_ff[k][x] <= window_ff[k][x+1];
            if (k < 6) window_ff[k][6] <= line_rdata[k*SAMPLE_W +: SAMPLE_W];
            else       window_ff[k][6] <= s1_sample_ff;
         end
      end
   end

   // stage 2: stencil sums from the shifted window
   logic             s2_valid_ff, s2_last_ff;
   logic [POS_W-1:0] s2_crow_ff, s2_ccol_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      s2_last_ff <= s1_last_ff;
      s2_crow_ff <= s1_crow_ff;
      s2_ccol_ff <= s1_ccol_ff;
   end

   function automatic logic signed [SW-1:0] wx(input logic signed [SAMPLE_W-1:0] v);
      wx = SW'(v);
   endfunction

   function automatic logic signed [SW-1:0] x3(input logic signed [SW-1:0] v);
      x3 = v + (v <<< 1);
   endfunction

   logic signed [SW-1:0] sum_a, sum_b, sum_c, sum_d, sre, sim;
   always_comb begin
      sum_a = wx(window_ff[6][3]) - x3(wx(window_ff[4][3]))
            + x3(wx(window_ff[2][3])) - wx(window_ff[0][3]);
      sum_b = (wx(window_ff[5][4]) - (wx(window_ff[3][4]) <<< 1) + wx(window_ff[1][4]))
            - (wx(window_ff[5][2]) - (wx(window_ff[3][2]) <<< 1) + wx(window_ff[1][2]));
      sum_c = (wx(window_ff[4][5]) - (wx(window_ff[4][3]) <<< 1) + wx(window_ff[4][1]))
            - (wx(window_ff[2][5]) - (wx(window_ff[2][3]) <<< 1) + wx(window_ff[2][1]));
      sum_d = wx(window_ff[3][6]) - x3(wx(window_ff[3][4]))
            + x3(wx(window_ff[3][2])) - wx(window_ff[3][0]);
      if (kind_ff == KIND_FIRST) begin
         sre = sum_a + sum_c;
         sim = sum_b + sum_d;
      end else begin
         sre = sum_a - x3(sum_c);
         sim = x3(sum_b) - sum_d;
      end
   end

   // stage 3: sums registered, split products against scale halves
   logic                 s3_valid_ff, s3_last_ff;
   logic [POS_W-1:0]     s3_crow_ff, s3_ccol_ff;
   logic signed [SW-1:0] s3_re_ff, s3_im_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_last_ff <= s2_last_ff;
      s3_crow_ff <= s2_crow_ff;
      s3_ccol_ff <= s2_ccol_ff;
      s3_re_ff   <= sre;
      s3_im_ff   <= sim;
   end

   logic [SW-1:0] mag_re, mag_im;
   assign mag_re = s3_re_ff[SW-1] ? SW'(-s3_re_ff) : SW'(s3_re_ff);
   assign mag_im = s3_im_ff[SW-1] ? SW'(-s3_im_ff) : SW'(s3_im_ff);

   // stage 4: partial products, then round, shift and saturate
   logic             s4_valid_ff, s4_last_ff, s4_neg_re_ff, s4_neg_im_ff;
   logic [POS_W-1:0] s4_crow_ff, s4_ccol_ff;
   logic [PW-1:0]    s4_qre_ff, s4_rre_ff, s4_qim_ff, s4_rim_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
      s4_last_ff   <= s3_last_ff;
      s4_crow_ff   <= s3_crow_ff;
      s4_ccol_ff   <= s3_ccol_ff;
      s4_neg_re_ff <= s3_re_ff[SW-1];
      s4_neg_im_ff <= s3_im_ff[SW-1];
      s4_qre_ff    <= PW'(mag_re) * PW'(scale_ff[31:16]);
      s4_rre_ff    <= PW'(mag_re) * PW'(scale_ff[15:0]) + PW'(64'd524288);
      s4_qim_ff    <= PW'(mag_im) * PW'(scale_ff[31:16]);
      s4_rim_ff    <= PW'(mag_im) * PW'(scale_ff[15:0]) + PW'(64'd524288);
   end

   function automatic logic signed [FLEX_W-1:0] finish(input logic [PW-1:0] q,
                                                       input logic [PW-1:0] r,
                                                       input logic neg);
      logic [PW-1:0] res;
      res = (q + (r >> 16)) >> 4;
      if (neg) begin
         if (res > PW'(64'd140737488355328)) finish = 48'sh8000_0000_0000;
         else                                finish = FLEX_W'(-res);
      end else begin
         if (res > PW'(64'd140737488355327)) finish = 48'sh7FFF_FFFF_FFFF;
         else                                finish = FLEX_W'(res);
      end
   endfunction

   rsp_item_type s4_item;
   always_comb begin
      s4_item.last    = s4_last_ff;
      s4_item.flex_im = finish(s4_qim_ff, s4_rim_ff, s4_neg_im_ff);
      s4_item.flex_re = finish(s4_qre_ff, s4_rre_ff, s4_neg_re_ff);
      s4_item.ccol    = s4_ccol_ff;
      s4_item.crow    = s4_crow_ff;
   end

   // output queue
   rsp_item_type   queue_ff [QD];
   logic [QA-1:0]  head_ff, tail_ff;
   logic [QA:0]    count_ff;
   logic [QA+1:0]  pending;
   logic           pop;

   assign pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (s4_valid_ff) queue_ff[tail_ff] <= s4_item;
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (s4_valid_ff) tail_ff <= tail_ff + QA'(1);
         if (pop)         head_ff <= head_ff + QA'(1);
         count_ff <= count_ff + (QA+1)'(s4_valid_ff) - (QA+1)'(pop);
      end
   end

   // in-flight results plus queued ones must leave room for one more
   assign pending = (QA+2)'(count_ff) + (QA+2)'(s1_valid_ff && s1_emit_ff)
                  + (QA+2)'(s2_valid_ff) + (QA+2)'(s3_valid_ff) + (QA+2)'(s4_valid_ff);
   assign req_tready = pending < (QA+2)'(QD);

   rsp_item_type head_item;
   assign head_item  = queue_ff[head_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {4'b0, head_item.flex_im, head_item.flex_re,
                        head_item.ccol, head_item.crow};
   assign rsp_tlast  = head_item.last;
endmodule

@@ rtl/core/tdfs_ram.sv @@
// Generic single-write, registered-read RAM.
module tdfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/core/tdfs_checker.sv @@
// Port-level checker for the flexion stencil, bound to the top level.
`include "third_derivative_flexion_stencil_assert.svh"
module tdfs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tdfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   // stalled result keeps its contents
   `TDFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // centers are always interior
   `TDFS_ASSERT_IMPL(a_center_interior, clock, reset, rsp_tvalid, (rsp_tdata[9:0] >= 10'd3) && (rsp_tdata[19:10] >= 10'd3))
   // queue empties on reset
   `TDFS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
endmodule

bind third_derivative_flexion_stencil tdfs_checker u_tdfs_checker (.*);
